@@ sv/gda_pkg.sv @@
`default_nettype none
package gda_pkg;

	localparam int YearW  = 14;
	localparam int MonthW = 4;
	localparam int DayW   = 5;
	localparam int AddW   = 16;
	localparam int AccW   = 17;
	localparam int RemW   = 9;

	localparam logic [AccW-1:0] Cycle400 = AccW'(400);
	localparam logic [RemW-1:0] RemLast  = RemW'(399);
	localparam logic [MonthW-1:0] MonFeb = MonthW'(1);
	localparam logic [MonthW-1:0] MonDec = MonthW'(11);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MOD  = 4'b0010,
		ST_WALK = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	typedef struct packed {
		logic ge;
		logic nz;
	} sub_flags_t;

	function automatic logic [DayW-1:0] base_len(input logic [MonthW-1:0] m);
		logic [DayW-1:0] n;
		case (m)
			4'd1:                     n = 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:  n = 5'd30;
			default:                  n = 5'd31;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

@@ sv/gda_sub.sv @@
`default_nettype none
module gda_sub (
	input  wire logic [gda_pkg::AccW-1:0] a,
	input  wire logic [gda_pkg::AccW-1:0] b,
	output logic [gda_pkg::AccW-1:0]      diff,
	output gda_pkg::sub_flags_t           flags
);

	logic [gda_pkg::AccW:0] full;

	assign full     = {1'b0, a} - {1'b0, b};
	assign diff     = full[gda_pkg::AccW-1:0];
	assign flags.ge = ~full[gda_pkg::AccW];
	assign flags.nz = (full[gda_pkg::AccW-1:0] != '0);

endmodule
`default_nettype wire

@@ sv/gda_len.sv @@
`default_nettype none
module gda_len (
	input  wire logic [gda_pkg::MonthW-1:0] month,
	input  wire logic [gda_pkg::RemW-1:0]   rem400,
	output logic [gda_pkg::DayW-1:0]        len
);

	logic leap;

	// rem400 is the year modulo 400, so the 4/100/400 rule reads off it directly
	assign leap = (rem400 == 9'd0) ||
		((rem400[1:0] == 2'd0) && (rem400 != 9'd100) && (rem400 != 9'd200) &&
		 (rem400 != 9'd300));

	assign len = gda_pkg::base_len(month) +
		gda_pkg::DayW'((month == gda_pkg::MonFeb) && leap);

endmodule
`default_nettype wire

@@ sv/gregorian_date_add_days_top.sv @@
`default_nettype none
// Adds a day count to a Gregorian date. One transfer in, one transfer out; the
// block takes a new date only once the previous result has been taken. An item
// runs through one shared subtractor: first the start year is reduced modulo 400
// by repeated subtraction, then the day total walks forward one month per cycle.
// Month 0 reads as January, months past 12 as December, day 0 as day 1; the
// result year wraps modulo 2^14 while leap years follow the full year.
module gregorian_date_add_days_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// start_year[13:0], start_month[17:14], start_day[22:18], add_count[38:23]
	input  wire logic [39:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// result_year[13:0], result_month[17:14], result_day[22:18]
	output logic [23:0]      m_tdata
);

	gda_pkg::state_t state_q;

	logic [gda_pkg::YearW-1:0]  year_q;
	logic [gda_pkg::YearW-1:0]  yrem_q;
	logic [gda_pkg::MonthW-1:0] mon_q;
	logic [gda_pkg::AccW-1:0]   day_q;

	logic [gda_pkg::YearW-1:0]  in_year;
	logic [gda_pkg::MonthW-1:0] in_month;
	logic [gda_pkg::DayW-1:0]   in_day;
	logic [gda_pkg::AddW-1:0]   in_add;
	logic [gda_pkg::MonthW-1:0] mon_idx;
	logic [gda_pkg::DayW-1:0]   day_fix;

	logic [gda_pkg::DayW-1:0]   len;
	logic [gda_pkg::AccW-1:0]   op_a;
	logic [gda_pkg::AccW-1:0]   op_b;
	logic [gda_pkg::AccW-1:0]   diff;
	gda_pkg::sub_flags_t        flags;
	logic [gda_pkg::RemW-1:0]   rem400;

	assign in_year  = s_tdata[13:0];
	assign in_month = s_tdata[17:14];
	assign in_day   = s_tdata[22:18];
	assign in_add   = s_tdata[38:23];

	always_comb begin
		if (in_month == 4'd0) begin
			mon_idx = 4'd0;
		end else if (in_month > 4'd12) begin
			mon_idx = gda_pkg::MonDec;
		end else begin
			mon_idx = in_month - 4'd1;
		end
		day_fix = (in_day == 5'd0) ? 5'd1 : in_day;
	end

	assign rem400 = yrem_q[gda_pkg::RemW-1:0];

	gda_len u_len (
		.month  (mon_q),
		.rem400 (rem400),
		.len    (len)
	);

	// the one subtractor serves the modulo pass and the month walk
	assign op_a = (state_q == gda_pkg::ST_MOD) ? gda_pkg::AccW'(yrem_q) : day_q;
	assign op_b = (state_q == gda_pkg::ST_MOD) ? gda_pkg::Cycle400 : gda_pkg::AccW'(len);

	gda_sub u_sub (
		.a     (op_a),
		.b     (op_b),
		.diff  (diff),
		.flags (flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gda_pkg::ST_IDLE;
		end else begin
			case (state_q)
				gda_pkg::ST_IDLE: begin
					if (s_tvalid) state_q <= gda_pkg::ST_MOD;
				end
				gda_pkg::ST_MOD: begin
					if (!flags.ge) state_q <= gda_pkg::ST_WALK;
				end
				gda_pkg::ST_WALK: begin
					if (!(flags.ge && flags.nz)) state_q <= gda_pkg::ST_DONE;
				end
				gda_pkg::ST_DONE: begin
					if (m_tready) state_q <= gda_pkg::ST_IDLE;
				end
				default: state_q <= gda_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			gda_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					year_q <= in_year;
					yrem_q <= in_year;
					mon_q  <= mon_idx;
					day_q  <= gda_pkg::AccW'(day_fix) + gda_pkg::AccW'(in_add);
				end
			end
			gda_pkg::ST_MOD: begin
				if (flags.ge) yrem_q <= diff[gda_pkg::YearW-1:0];
			end
			gda_pkg::ST_WALK: begin
				if (flags.ge && flags.nz) begin
					day_q <= diff;
					if (mon_q == gda_pkg::MonDec) begin
						mon_q  <= '0;
						year_q <= year_q + 14'd1;
						if (rem400 == gda_pkg::RemLast) begin
							yrem_q <= '0;
						end else begin
							yrem_q <= gda_pkg::YearW'(rem400) + 14'd1;
						end
					end else begin
						mon_q <= mon_q + 4'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign s_tready = (state_q == gda_pkg::ST_IDLE);
	assign m_tvalid = (state_q == gda_pkg::ST_DONE);
	assign m_tdata  = {1'b0, day_q[gda_pkg::DayW-1:0], mon_q + 4'd1, year_q};

endmodule
`default_nettype wire

@@ sv/gda_chk.sv @@
`default_nettype none
module gda_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata
);

	// one item in flight: never ready while a result is pending
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("ready while result pending");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (!s_tready && !m_tvalid))
		else $error("not busy after input transfer");

	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready) |=> (s_tready && !m_tvalid))
		else $error("not idle after output transfer");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[17:14] != 4'd0) && (m_tdata[17:14] <= 4'd12) &&
			(m_tdata[22:18] != 5'd0)))
		else $error("result date out of range");

endmodule

bind gregorian_date_add_days_top gda_chk u_gda_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
